>>> sv/fcd_pkg.sv
package fcd_pkg;

    localparam int PIX_W     = 8;
    localparam int DENS_W    = 17;
    localparam int FNUM_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SKIP      = 8'd1;

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd30;
    localparam logic [PIX_W-1:0] SKIP_RESET   = 8'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic emit;
    } fcd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic measured;
    } fcd_sts_t;

endpackage

>>> sv/fcd_ctrl.sv
module fcd_ctrl #(
    parameter int QUO_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  logic             m_tready,
    output logic             m_tvalid,
    input  fcd_pkg::fcd_sts_t sts,
    output fcd_pkg::fcd_cmd_t cmd
);
    import fcd_pkg::*;

    localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   bit_cnt_reg;
    logic [CNT_W-1:0]   bit_cnt_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;

    assign s_tready   = (state_reg == ST_ACCUM);
    assign m_tvalid   = m_tvalid_reg;
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.load   = (state_reg == ST_PREP);
    assign cmd.step   = (state_reg == ST_DIV);
    assign cmd.emit   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (cmd.accept && s_tlast)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // Skipped frames need no division; the held density goes out.
                if (sts.measured)
                begin
                    state_next   = ST_DIV;
                    bit_cnt_next = CNT_W'(QUO_W - 1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (cmd.emit)
                begin
                    state_next    = ST_ACCUM;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_ACCUM;
            bit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> sv/fcd_dp.sv
module fcd_dp #(
    parameter int MAX_FRAME_PIXELS  = 262144,
    parameter int DENSITY_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fcd_pkg::fcd_cmd_t              cmd,
    output fcd_pkg::fcd_sts_t              sts,
    input  logic [fcd_pkg::PIX_W-1:0]      cur_pixel,
    input  logic [fcd_pkg::PIX_W-1:0]      ref_pixel,
    input  logic                           cfg_valid,
    input  logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcd_pkg::CFG_DAT_W-1:0]  cfg_data,
    output logic [fcd_pkg::DENS_W-1:0]     density,
    output logic [fcd_pkg::FNUM_W-1:0]     frame_number,
    output logic                           fresh,
    output logic                           oversize
);
    import fcd_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int QUO_W = DENSITY_FRAC_BITS + 1;
    localparam int NUM_W = CNT_W + QUO_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_PIXELS);

    logic [PIX_W-1:0]  thresh_reg;
    logic [PIX_W-1:0]  skip_reg;
    logic [PIX_W-1:0]  skip_phase_reg;
    logic [CNT_W-1:0]  pix_total_reg;
    logic [CNT_W-1:0]  chg_total_reg;
    logic              oversize_seen_reg;
    logic [DENS_W-1:0] held_reg;
    logic [FNUM_W-1:0] fnum_reg;
    logic              fresh_reg;
    logic              oversize_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  num_lo_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic              measured;
    logic [PIX_W-1:0]  diff;
    logic [NUM_W-1:0]  num;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              trial_ge;

    assign measured     = (skip_phase_reg == '0);
    assign sts.measured = measured;
    assign diff         = (cur_pixel > ref_pixel) ? (cur_pixel - ref_pixel)
                                                  : (ref_pixel - cur_pixel);

    // Rounded numerator: changed * 2^frac + total / 2.
    assign num = (NUM_W'(chg_total_reg) << DENSITY_FRAC_BITS)
               + NUM_W'(pix_total_reg >> 1);

    // One restoring-division step per cycle; the remainder stays below total.
    assign trial     = {rem_reg, num_lo_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, pix_total_reg};
    assign trial_ge  = (trial >= {1'b0, pix_total_reg});

    assign density      = held_reg;
    assign frame_number = fnum_reg;
    assign fresh        = fresh_reg;
    assign oversize     = oversize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg        <= THRESH_RESET;
            skip_reg          <= SKIP_RESET;
            skip_phase_reg    <= '0;
            pix_total_reg     <= '0;
            chg_total_reg     <= '0;
            oversize_seen_reg <= 1'b0;
            held_reg          <= '0;
            fnum_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_IDX_THRESHOLD)
                begin
                    thresh_reg <= cfg_data;
                end
                else if (cfg_index == CFG_IDX_SKIP)
                begin
                    skip_reg <= cfg_data;
                end
            end
            if (cmd.accept)
            begin
                if (pix_total_reg < MAX_CNT)
                begin
                    pix_total_reg <= pix_total_reg + 1'b1;
                    if (measured && (diff > thresh_reg))
                    begin
                        chg_total_reg <= chg_total_reg + 1'b1;
                    end
                end
                else
                begin
                    oversize_seen_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                if (measured)
                begin
                    held_reg <= DENS_W'(quo_reg);
                end
                fnum_reg <= fnum_reg + 1'b1;
                if (skip_phase_reg >= skip_reg)
                begin
                    skip_phase_reg <= '0;
                end
                else
                begin
                    skip_phase_reg <= skip_phase_reg + 1'b1;
                end
                pix_total_reg     <= '0;
                chg_total_reg     <= '0;
                oversize_seen_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg    <= num[NUM_W-1:QUO_W];
            num_lo_reg <= num[QUO_W-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg    <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            num_lo_reg <= num_lo_reg << 1;
            quo_reg    <= {quo_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.emit)
        begin
            fresh_reg    <= measured;
            oversize_reg <= oversize_seen_reg;
        end
    end

endmodule

>>> sv/frame_change_density_core.sv
// Pixels are taken one per cycle inside a frame.
// After the request carrying tlast, s_tready stays low through ST_PREP, then on a
// measured frame through ST_DIV (one division step per quotient bit of the divider),
// and then through ST_DONE until the previous result has been taken on m_tready.
// The result is presented as s_tready rises again and holds until taken.
// rst_n clears all counters, the held density and the frame count asynchronously.
module frame_change_density_core #(
    parameter int MAX_FRAME_PIXELS  = 262144,
    parameter int DENSITY_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fcd_pkg::S_TDATA_W-1:0]    s_tdata,  // cur_pixel, ref_pixel
    input  logic                             s_tlast,  // frame_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fcd_pkg::M_TDATA_W-1:0]    m_tdata,  // density, frame_number, zero pad
    output logic [fcd_pkg::M_TUSER_W-1:0]    m_tuser,  // fresh, oversize
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcd_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import fcd_pkg::*;

    fcd_cmd_t          cmd;
    fcd_sts_t          sts;
    logic [DENS_W-1:0] density;
    logic [FNUM_W-1:0] frame_number;
    logic              fresh;
    logic              oversize;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(M_TDATA_W - DENS_W - FNUM_W){1'b0}}, frame_number, density};
    assign m_tuser   = {oversize, fresh};

    fcd_ctrl #(
        .QUO_W(DENSITY_FRAC_BITS + 1)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    fcd_dp #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
        .DENSITY_FRAC_BITS(DENSITY_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cur_pixel    (s_tdata[PIX_W-1:0]),
        .ref_pixel    (s_tdata[2*PIX_W-1:PIX_W]),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .density      (density),
        .frame_number (frame_number),
        .fresh        (fresh),
        .oversize     (oversize)
    );

endmodule

>>> bench/tb_frame_change_density_core.sv
module tb_frame_change_density_core;

    import fcd_pkg::*;

    localparam int MAX_PIXELS  = 262144;
    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = FRAC_BITS + 3;
    localparam int CYCLE_LIMIT = 4000000;

    typedef enum int {
        MIX_RANDOM,
        MIX_NEAR_THRESHOLD,
        MIX_STILL,
        MIX_EXTREME
    } pix_mix_t;

    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic [FNUM_W-1:0] frame_number;
        logic              fresh;
        logic              oversize;
    } frame_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // Shadow copy of the block's registers and frame state.
    logic [PIX_W-1:0]  threshold_reg    = THRESH_RESET;
    logic [PIX_W-1:0]  skip_reg         = SKIP_RESET;
    logic [PIX_W-1:0]  measure_phase    = '0;
    int unsigned       pixels_in_frame  = 0;
    int unsigned       changed_in_frame = 0;
    logic [DENS_W-1:0] last_density     = '0;
    logic [FNUM_W-1:0] frames_done      = '0;
    logic              frame_overflowed = 1'b0;

    frame_result_t expected_frames[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int rx_stall_left  = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;

    frame_change_density_core #(
        .MAX_FRAME_PIXELS  (MAX_PIXELS),
        .DENSITY_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[frame_change_density_core] ERROR");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    function automatic void count_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] bg,
                                        input bit last);
        logic [PIX_W-1:0] diff;
        bit               measured;
        longint unsigned  numer;
        frame_result_t    res;
        measured = (measure_phase == 0);
        diff = (cur > bg) ? cur - bg : bg - cur;
        if (pixels_in_frame < MAX_PIXELS)
        begin
            pixels_in_frame++;
            if (measured && diff > threshold_reg)
                changed_in_frame++;
        end
        else
        begin
            frame_overflowed = 1'b1;
        end
        if (!last)
            return;
        frames_done = frames_done + 1'b1;
        if (measured)
        begin
            numer = (longint'(changed_in_frame) << FRAC_BITS) + pixels_in_frame / 2;
            last_density = (pixels_in_frame != 0) ? DENS_W'(numer / pixels_in_frame) : '0;
        end
        res.density      = last_density;
        res.frame_number = frames_done;
        res.fresh        = measured;
        res.oversize     = frame_overflowed;
        expected_frames.push_back(res);
        measure_phase    = (measure_phase >= skip_reg) ? '0 : measure_phase + 1'b1;
        pixels_in_frame  = 0;
        changed_in_frame = 0;
        frame_overflowed = 1'b0;
    endfunction

    function automatic logic [2*PIX_W-1:0] make_pixel(input pix_mix_t mix);
        int bg_v;
        int cur_v;
        int offset;
        bg_v = $urandom_range(255);
        case (mix)
            MIX_RANDOM:
                cur_v = $urandom_range(255);
            MIX_NEAR_THRESHOLD:
            begin
                // Land one below, on, or one above the threshold.
                offset = int'(threshold_reg) + int'($urandom_range(2)) - 1;
                cur_v = $urandom_range(1) ? bg_v + offset : bg_v - offset;
                if (cur_v > 255 || cur_v < 0)
                    cur_v = $urandom_range(255);
            end
            MIX_STILL:
                cur_v = bg_v;
            default:
            begin
                bg_v  = $urandom_range(1) * 255;
                cur_v = $urandom_range(1) * 255;
            end
        endcase
        return {PIX_W'(bg_v), PIX_W'(cur_v)};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    endtask

    task automatic check_frame_result();
        frame_result_t want;
        if (expected_frames.size() == 0)
        begin
            report_mismatch("frame result with none pending", m_tdata[DENS_W +: FNUM_W], 0);
        end
        else
        begin
            want = expected_frames.pop_front();
            if (m_tdata[0 +: DENS_W] !== want.density)
                report_mismatch("density", m_tdata[0 +: DENS_W], want.density);
            if (m_tdata[DENS_W +: FNUM_W] !== want.frame_number)
                report_mismatch("frame_number", m_tdata[DENS_W +: FNUM_W], want.frame_number);
            if (m_tdata[M_TDATA_W-1:DENS_W+FNUM_W] !== '0)
                report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:DENS_W+FNUM_W], 0);
            if (m_tuser[0] !== want.fresh)
                report_mismatch("fresh", m_tuser[0], want.fresh);
            if (m_tuser[1] !== want.oversize)
                report_mismatch("oversize", m_tuser[1], want.oversize);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_frame_result();
        if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_stall_left = rx_calm ? 0 : pick_gap();
            m_tready <= (rx_stall_left == 0);
        end
    end

    // A valid that stays high across back-to-back requests is never dropped in between.
    task automatic send_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] bg,
                              input bit last);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bg, cur};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        count_pixel(cur, bg, last);
    endtask

    task automatic send_frame(input int len, input pix_mix_t mix);
        logic [2*PIX_W-1:0] px;
        for (int i = 0; i < len; i++)
        begin
            px = make_pixel(mix);
            send_pixel(px[PIX_W-1:0], px[2*PIX_W-1:PIX_W], i == len - 1);
        end
    endtask

    // Stop sending, wait for every pending frame result, then let the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_IDX_THRESHOLD)
            threshold_reg = value;
        else if (idx == CFG_IDX_SKIP)
            skip_reg = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [PIX_W-1:0] thr, input logic [PIX_W-1:0] skip);
        settle();
        write_register(CFG_IDX_THRESHOLD, thr);
        write_register(CFG_IDX_SKIP, skip);
    endtask

    function automatic logic [PIX_W-1:0] random_threshold();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return PIX_W'($urandom_range(255));
            default: return PIX_W'($urandom_range(80));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] random_skip();
        case ($urandom_range(19))
            0: return '1;
            1, 2, 3, 4, 5, 6, 7, 8: return '0;
            default: return PIX_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Reset threshold first, then both threshold extremes and the strict compare.
    task automatic test_threshold_edges();
        send_pixel(8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 1'b0);
        send_pixel(8'd100, 8'd130, 1'b0);
        send_pixel(8'd100, 8'd131, 1'b1);
        send_pixel(8'd0, 8'd0, 1'b1);
        configure(8'd0, 8'd0);
        send_pixel(8'd7, 8'd7, 1'b0);
        send_pixel(8'd7, 8'd8, 1'b1);
        configure(8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 1'b1);
        configure(8'd254, 8'd0);
        send_pixel(8'd255, 8'd0, 1'b1);
    endtask

    // Skipped frames hold the density; then the skip count shrinks below the phase.
    task automatic test_skip_sequence();
        configure(8'd40, 8'd2);
        for (int f = 0; f < 4; f++)
        begin
            send_pixel(8'd10, 8'd90, 1'b0);
            send_pixel(8'd50, 8'd55, 1'b1);
        end
        configure(8'd40, 8'd0);
        send_pixel(8'd0, 8'd200, 1'b1);
        send_pixel(8'd0, 8'd200, 1'b0);
        send_pixel(8'd3, 8'd3, 1'b1);
    endtask

    task automatic test_threshold_mid_frame();
        configure(8'd30, 8'd0);
        send_pixel(8'd60, 8'd80, 1'b0);
        send_pixel(8'd80, 8'd60, 1'b0);
        settle();
        write_register(CFG_IDX_THRESHOLD, 8'd10);
        send_pixel(8'd60, 8'd80, 1'b0);
        send_pixel(8'd80, 8'd60, 1'b1);
    endtask

    // The widest skip setting, run all the way around the phase cycle.
    task automatic test_skip_wraparound();
        configure(random_threshold(), 8'd255);
        for (int f = 0; f < 258; f++)
            send_frame(1, pix_mix_t'($urandom_range(3)));
    endtask

    task automatic test_random_frames(input int item_budget);
        int       sent;
        int       len;
        pix_mix_t mix;
        logic [2*PIX_W-1:0] px;
        sent = 0;
        while (sent < item_budget)
        begin
            if ($urandom_range(7) == 0)
                tx_calm = !tx_calm;
            if ($urandom_range(7) == 0)
                rx_calm = !rx_calm;
            if ($urandom_range(9) == 0)
                configure(random_threshold(), random_skip());
            len = ($urandom_range(9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 200);
            mix = pix_mix_t'($urandom_range(3));
            for (int i = 0; i < len; i++)
            begin
                if (i == len / 2 && i != 0 && $urandom_range(19) == 0)
                begin
                    settle();
                    write_register(CFG_IDX_THRESHOLD, random_threshold());
                end
                px = make_pixel(mix);
                send_pixel(px[PIX_W-1:0], px[2*PIX_W-1:PIX_W], i == len - 1);
            end
            sent += len;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_threshold_edges();
        test_skip_sequence();
        test_threshold_mid_frame();
        test_skip_wraparound();
        test_random_frames(1250);
        settle();
        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("[frame_change_density_core] OK");
        else
            $display("[frame_change_density_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/fcd_pkg.sv
sv/fcd_ctrl.sv
sv/fcd_dp.sv
sv/frame_change_density_core.sv
bench/tb_frame_change_density_core.sv
